// File: rtl/ptaf_pkg.sv
// Shared types and constants for the prefix trie access filter.
package ptaf_pkg;

	localparam int NODE_COUNT = 4096;
	localparam int ADDR_BITS  = 128;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int USED_W     = $clog2(NODE_COUNT + 1);
	localparam int LEN_W      = 8;
	localparam int ENTRY_W    = 2 * NODE_W + 1;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	localparam logic [PADDR_W-1:0] REG_DEFAULT_ALLOW = 3'd0;

	typedef struct packed {
		logic        operation;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix_len;
		logic        allow_bit;
	} cmd_t;

	typedef struct packed {
		logic allowed;
		logic status;
	} res_t;

	typedef struct packed {
		logic [NODE_W-1:0] child_zero;
		logic [NODE_W-1:0] child_one;
		logic              allow;
	} node_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		node_t             wdata;
		logic              re;
		logic [NODE_W-1:0] raddr;
	} ram_req_t;

endpackage

// File: rtl/ptaf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ptaf_cfg.sv
// APB register block holding the default verdict (root allow bit).
module ptaf_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ptaf_pkg::PADDR_W-1:0]   paddr,
	input  logic [ptaf_pkg::PDATA_W-1:0]   pwdata,
	output logic [ptaf_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output logic                           default_allow
);

	logic default_allow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_allow_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == ptaf_pkg::REG_DEFAULT_ALLOW) begin
			default_allow_q <= pwdata[0];
		end
	end

	always_comb begin
		case (paddr)
			ptaf_pkg::REG_DEFAULT_ALLOW: prdata = ptaf_pkg::PDATA_W'(default_allow_q);
			default:                     prdata = '0;
		endcase
	end

	assign pready        = 1'b1;
	assign default_allow = default_allow_q;

endmodule

// File: rtl/ptaf_walk.sv
// Trie walk sequencer: steps one trie level at a time for insert and lookup.
module ptaf_walk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  ptaf_pkg::cmd_t     cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output ptaf_pkg::res_t     res,
	input  logic               default_allow,
	output ptaf_pkg::ram_req_t ram_req,
	input  ptaf_pkg::node_t    ram_rdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_LINK = 2'd2;

	logic [1:0]                      state_q;
	logic                            op_q;
	logic                            allow_in_q;
	logic [ptaf_pkg::LEN_W-1:0]      len_q;
	logic [ptaf_pkg::LEN_W-1:0]      lvl_q;
	logic [ptaf_pkg::ADDR_BITS-1:0]  addr_q;
	logic [ptaf_pkg::NODE_W-1:0]     node_q;
	logic                            src_ram_q;
	ptaf_pkg::node_t                 cur_q;
	ptaf_pkg::node_t                 par_q;
	logic [ptaf_pkg::NODE_W-1:0]     par_idx_q;
	logic [ptaf_pkg::USED_W-1:0]     used_q;
	logic [ptaf_pkg::NODE_W-1:0]     root_c0_q;
	logic [ptaf_pkg::NODE_W-1:0]     root_c1_q;
	logic                            res_valid_q;
	ptaf_pkg::res_t                  res_q;

	ptaf_pkg::node_t             entry;
	ptaf_pkg::node_t             fresh;
	ptaf_pkg::node_t             par_upd;
	logic                        bit_w;
	logic [ptaf_pkg::NODE_W-1:0] child;
	logic [ptaf_pkg::NODE_W-1:0] new_idx;
	logic                        is_lookup;
	logic                        last_lvl;
	logic                        hit;
	logic                        full;
	logic                        fin;
	logic                        res_free;
	logic                        res_load;
	logic                        new_allow;
	logic [ptaf_pkg::LEN_W-1:0]  len_sat;
	logic [127:0]                addr_full;

	// Current node comes from the RAM after a read, else from the held copy.
	assign entry     = src_ram_q ? ram_rdata : cur_q;
	assign bit_w     = addr_q[ptaf_pkg::ADDR_BITS-1];
	assign child     = bit_w ? entry.child_one : entry.child_zero;
	assign is_lookup = (op_q == ptaf_pkg::OP_LOOKUP);
	assign last_lvl  = is_lookup ? (lvl_q == ptaf_pkg::LEN_W'(ptaf_pkg::ADDR_BITS))
	                             : (lvl_q == len_q);
	assign hit       = (child != '0);
	assign full      = (used_q == ptaf_pkg::USED_W'(ptaf_pkg::NODE_COUNT));
	assign fin       = last_lvl || (!hit && (is_lookup || full));
	assign res_free  = !res_valid_q || res_ready;
	assign res_load  = (state_q == ST_STEP) && fin && res_free;
	assign new_idx   = used_q[ptaf_pkg::NODE_W-1:0];
	assign new_allow = (lvl_q + ptaf_pkg::LEN_W'(1) == len_q) ? allow_in_q : entry.allow;
	assign len_sat   = (cmd.prefix_len > ptaf_pkg::LEN_W'(ptaf_pkg::ADDR_BITS))
	                 ? ptaf_pkg::LEN_W'(ptaf_pkg::ADDR_BITS) : cmd.prefix_len;
	assign addr_full = {cmd.addr_high, cmd.addr_low};

	always_comb begin
		fresh            = '0;
		fresh.allow      = new_allow;
		par_upd          = entry;
		if (bit_w) begin
			par_upd.child_one = new_idx;
		end else begin
			par_upd.child_zero = new_idx;
		end
	end

	always_comb begin
		ram_req       = '0;
		ram_req.raddr = child;
		case (state_q)
			ST_STEP: begin
				if (!fin) begin
					if (hit) begin
						ram_req.re = 1'b1;
					end else begin
						ram_req.we    = 1'b1;
						ram_req.waddr = new_idx;
						ram_req.wdata = fresh;
					end
				end
			end
			ST_LINK: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = par_idx_q;
				ram_req.wdata = par_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= ptaf_pkg::USED_W'(1);
			root_c0_q   <= '0;
			root_c1_q   <= '0;
			res_valid_q <= 1'b0;
			src_ram_q   <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q   <= ST_STEP;
						src_ram_q <= 1'b0;
					end
				end
				ST_STEP: begin
					if (fin) begin
						// Hold here until the result register frees up.
						if (res_free) begin
							state_q <= ST_IDLE;
						end
					end else if (hit) begin
						src_ram_q <= 1'b1;
					end else begin
						src_ram_q <= 1'b0;
						used_q    <= used_q + ptaf_pkg::USED_W'(1);
						if (node_q == '0) begin
							if (bit_w) begin
								root_c1_q <= new_idx;
							end else begin
								root_c0_q <= new_idx;
							end
						end else begin
							state_q <= ST_LINK;
						end
					end
				end
				ST_LINK: begin
					state_q <= ST_STEP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					op_q       <= cmd.operation;
					allow_in_q <= cmd.allow_bit;
					len_q      <= len_sat;
					lvl_q      <= '0;
					addr_q     <= addr_full[127 -: ptaf_pkg::ADDR_BITS];
					node_q     <= '0;
					cur_q      <= '{child_zero: root_c0_q, child_one: root_c1_q,
					                allow: default_allow};
				end
			end
			ST_STEP: begin
				if (fin) begin
					if (res_free) begin
						res_q.allowed <= is_lookup ? entry.allow : 1'b0;
						res_q.status  <= (!is_lookup && !last_lvl) ? ptaf_pkg::STATUS_FULL
						                                           : ptaf_pkg::STATUS_OK;
					end
				end else begin
					lvl_q  <= lvl_q + ptaf_pkg::LEN_W'(1);
					addr_q <= addr_q << 1;
					if (hit) begin
						node_q <= child;
					end else begin
						node_q    <= new_idx;
						cur_q     <= fresh;
						par_q     <= par_upd;
						par_idx_q <= node_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/prefix_trie_access_filter_core.sv
// Top level: longest-prefix-match access filter over a binary trie of 128-bit addresses.
// Lookup: follows matching children level by level and returns the deepest node's allow bit.
// Insert: reads each existing level and writes each created node, then links it into its parent
// (a child of the root is linked in a register instead). One item at a time: cmd_ready is
// high only while idle, so the next transfer waits until the result has loaded.
// Reset empties the trie to the root and clears default_allow; nodes are zeroed as made.
module prefix_trie_access_filter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  ptaf_pkg::cmd_t               cmd,
	output logic                         res_valid,
	input  logic                         res_ready,
	output ptaf_pkg::res_t               res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ptaf_pkg::PADDR_W-1:0] paddr,
	input  logic [ptaf_pkg::PDATA_W-1:0] pwdata,
	output logic [ptaf_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	logic               default_allow;
	ptaf_pkg::ram_req_t ram_req;
	ptaf_pkg::node_t    ram_rdata;

	ptaf_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.default_allow (default_allow)
	);

	ptaf_walk u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.default_allow (default_allow),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata)
	);

	ptaf_ram #(
		.WIDTH (ptaf_pkg::ENTRY_W),
		.DEPTH (ptaf_pkg::NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("walker took a second transfer while busy");

	a_full_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.status == ptaf_pkg::STATUS_FULL && res.allowed))
		else $error("table-full result carries an allow verdict");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == ptaf_pkg::REG_DEFAULT_ALLOW
		|=> default_allow == $past(pwdata[0]))
		else $error("default_allow write lost");

endmodule

// File: tb/trie_verdict_checker.sv
// Checker for the prefix trie access filter: keeps its own trie and compares every result.
module trie_verdict_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  ptaf_pkg::cmd_t               cmd,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  ptaf_pkg::res_t               res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ptaf_pkg::PADDR_W-1:0] paddr,
	input  logic [ptaf_pkg::PDATA_W-1:0] pwdata,
	input  logic                         pready,
	output int                           pending,
	output int                           errors
);
	import ptaf_pkg::*;

	logic [NODE_W-1:0] kid_zero [NODE_COUNT];
	logic [NODE_W-1:0] kid_one [NODE_COUNT];
	logic              verdict [NODE_COUNT];
	int unsigned       nodes_made;
	res_t              verdict_queue [$];
	res_t              want;

	// Walk the trie for one command; inserts grow the trie as they go.
	function automatic res_t walk_trie(input cmd_t c);
		logic [ADDR_BITS-1:0] path;
		logic [NODE_W-1:0]    at;
		logic [NODE_W-1:0]    nxt;
		int unsigned          depth;
		int unsigned          lvl;
		logic                 b;
		bit                   done;
		res_t                 r;
		path = {c.addr_high, c.addr_low};
		at = '0;
		lvl = 0;
		done = 1'b0;
		r.allowed = 1'b0;
		r.status = STATUS_OK;
		if (c.operation == OP_LOOKUP) begin
			while (!done && lvl < ADDR_BITS) begin
				b = path[ADDR_BITS-1-lvl];
				nxt = b ? kid_one[at] : kid_zero[at];
				if (nxt == '0) begin
					done = 1'b1;
				end else begin
					at = nxt;
					lvl++;
				end
			end
			r.allowed = verdict[at];
		end else begin
			// saturate overlong prefixes to the address width
			depth = (c.prefix_len > ADDR_BITS) ? ADDR_BITS : c.prefix_len;
			while (!done && lvl < depth) begin
				b = path[ADDR_BITS-1-lvl];
				nxt = b ? kid_one[at] : kid_zero[at];
				if (nxt == '0) begin
					if (nodes_made >= NODE_COUNT) begin
						// out of nodes: stop here, keep what was built
						r.status = STATUS_FULL;
						done = 1'b1;
					end else begin
						nxt = NODE_W'(nodes_made);
						nodes_made++;
						kid_zero[nxt] = '0;
						kid_one[nxt] = '0;
						verdict[nxt] = (lvl + 1 == depth) ? c.allow_bit : verdict[at];
						if (b)
							kid_one[at] = nxt;
						else
							kid_zero[at] = nxt;
					end
				end
				if (!done) begin
					at = nxt;
					lvl++;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_made = 1;
			kid_zero[0] = '0;
			kid_one[0] = '0;
			verdict[0] = 1'b0;
			verdict_queue.delete();
			pending = 0;
			errors = 0;
		end else begin
			// retire results before queueing a new command from the same edge
			if (res_valid && res_ready) begin
				if (verdict_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer, got allowed %0b status %0b",
						$time, res.allowed, res.status);
				end else begin
					want = verdict_queue.pop_front();
					if (res.allowed !== want.allowed) begin
						errors++;
						$display("%0t: allowed mismatch, expected %0b, got %0b",
							$time, want.allowed, res.allowed);
					end
					if (res.status !== want.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0b, got %0b",
							$time, want.status, res.status);
					end
				end
			end
			if (cmd_valid && cmd_ready)
				verdict_queue.push_back(walk_trie(cmd));
			if (psel && penable && pwrite && pready && paddr == REG_DEFAULT_ALLOW)
				verdict[0] = pwdata[0];
			pending = verdict_queue.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the prefix trie access filter testbench: clock, reset, stimulus and verdict.
module testbench;
	import ptaf_pkg::*;

	localparam int STALL_LIMIT = 10000;
	localparam int HOLD_CYCLES = 1000;

	typedef struct {
		logic [ADDR_BITS-1:0] bits;
		int unsigned          span;
	} prefix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	cmd_t               cmd = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	res_t               res;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 pending;
	int                 fail_count;
	int                 idle_cycles = 0;
	int                 burst_left = 0;
	prefix_t            known_prefixes [$];

	prefix_trie_access_filter_core dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	trie_verdict_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.pending(pending), .errors(fail_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: rotating stall patterns, plus one long hold-off while commands queue up.
	initial begin
		int  cyc;
		bit  held;
		cyc = 0;
		held = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && cyc > 5000 && res_valid && cmd_valid) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					res_ready <= 1'b0;
					@(posedge clk);
					cyc++;
				end
			end else begin
				case ((cyc / 600) % 4)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					2: res_ready <= ($urandom_range(0, 4) == 0);
					default: res_ready <= cyc[3];
				endcase
				@(posedge clk);
				cyc++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	function automatic cmd_t item(input logic op, input logic [63:0] hi, input logic [63:0] lo,
			input logic [7:0] len, input logic al);
		cmd_t c;
		c.operation = op;
		c.addr_high = hi;
		c.addr_low = lo;
		c.prefix_len = len;
		c.allow_bit = al;
		return c;
	endfunction

	// Mostly reuse known prefixes so inserts branch and lookups land on deep paths.
	function automatic cmd_t random_cmd(input bit fill);
		cmd_t                 c;
		logic [ADDR_BITS-1:0] a;
		logic [ADDR_BITS-1:0] mask;
		prefix_t              p;
		int unsigned          pick;
		int unsigned          k;
		a = {$urandom, $urandom, $urandom, $urandom};
		c.allow_bit = 1'($urandom_range(0, 1));
		c.prefix_len = 8'($urandom_range(0, 255));
		if (fill) begin
			c.operation = OP_INSERT;
			c.prefix_len = 8'd128;
		end else if ($urandom_range(0, 99) < 40) begin
			c.operation = OP_INSERT;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				c.prefix_len = 8'd0;
			else if (pick < 75)
				c.prefix_len = 8'($urandom_range(1, 24));
			else if (pick < 90)
				c.prefix_len = 8'($urandom_range(25, 128));
			else
				c.prefix_len = 8'($urandom_range(129, 255));
			if (known_prefixes.size() != 0 && $urandom_range(0, 9) < 7) begin
				p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
				k = $urandom_range(0, p.span);
				mask = (k == 0) ? '0 : ~'0 << (ADDR_BITS - k);
				a = (p.bits & mask) | (a & ~mask);
			end
		end else begin
			c.operation = OP_LOOKUP;
			if (known_prefixes.size() != 0 && $urandom_range(0, 4) != 0) begin
				p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
				pick = $urandom_range(0, 3);
				mask = ~'0 << (ADDR_BITS - p.span);
				if (pick == 0)
					a = p.bits;
				else
					a = (p.bits & mask) | (a & ~mask);
				// knock one bit off the stored path
				if (pick == 3)
					a = a ^ ({{(ADDR_BITS-1){1'b0}}, 1'b1}
						<< (ADDR_BITS - 1 - $urandom_range(0, p.span - 1)));
			end
		end
		c.addr_high = a[127:64];
		c.addr_low = a[63:0];
		return c;
	endfunction

	// Offer one command; keep valid high when the next one follows in the same burst.
	task automatic issue(input cmd_t c, input bit more);
		bit          ok;
		prefix_t     p;
		int unsigned gap;
		cmd <= c;
		cmd_valid <= 1'b1;
		do begin
			@(negedge clk);
			ok = cmd_ready;
			@(posedge clk);
		end while (!ok);
		if (c.operation == OP_INSERT && c.prefix_len != 0) begin
			p.bits = {c.addr_high, c.addr_low};
			p.span = (c.prefix_len > ADDR_BITS) ? ADDR_BITS : c.prefix_len;
			known_prefixes.push_back(p);
		end
		burst_left--;
		if (!more) begin
			cmd_valid <= 1'b0;
		end else if (burst_left <= 0) begin
			cmd_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
	endtask

	task automatic run_random(input int n, input bit fill);
		for (int i = 0; i < n; i++)
			issue(random_cmd(fill), i != n - 1);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_default(input logic [PDATA_W-1:0] value);
		bit ok;
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_DEFAULT_ALLOW;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ok = pready;
			@(posedge clk);
		end while (!ok);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty trie, then the empty prefix
		issue(item(OP_LOOKUP, 64'h0, 64'h0, 8'd128, 1'b0), 1);
		issue(item(OP_INSERT, '1, '1, 8'd0, 1'b1), 1);
		issue(item(OP_LOOKUP, '1, '1, 8'd128, 1'b0), 0);
		write_default(32'hFFFF_FFFF);
		issue(item(OP_LOOKUP, '1, '1, 8'd128, 1'b0), 1);
		issue(item(OP_INSERT, 64'h8000_0000_0000_0000, 64'h0, 8'd1, 1'b0), 1);
		issue(item(OP_INSERT, '1, '1, 8'd128, 1'b1), 1);
		issue(item(OP_LOOKUP, '1, '1, 8'd128, 1'b0), 1);
		issue(item(OP_LOOKUP, '1, 64'h0, 8'd128, 1'b1), 1);
		// an existing node keeps its allow bit
		issue(item(OP_INSERT, 64'h8000_0000_0000_0000, 64'h0, 8'd1, 1'b1), 1);
		issue(item(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0, 8'd128, 1'b0), 1);
		issue(item(OP_LOOKUP, 64'h0, 64'h0, 8'd128, 1'b0), 1);
		// overlong prefixes saturate
		issue(item(OP_INSERT, 64'h0, 64'h0, 8'd200, 1'b0), 1);
		issue(item(OP_LOOKUP, 64'h0, 64'h0, 8'd128, 1'b1), 1);
		issue(item(OP_LOOKUP, 64'h0, 64'h1, 8'd128, 1'b0), 1);
		issue(item(OP_INSERT, 64'h0, 64'h0, 8'd255, 1'b1), 1);
		issue(item(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd128, 1'b0), 1);
		issue(item(OP_LOOKUP, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd128, 1'b1), 1);
		issue(item(OP_LOOKUP, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, 8'd0, 1'b0), 1);
		issue(item(OP_INSERT, 64'h0, '1, 8'd128, 1'b1), 1);
		issue(item(OP_LOOKUP, 64'h0, '1, 8'd255, 1'b0), 1);
		issue(item(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, '1, 8'd127, 1'b1), 1);
		issue(item(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0, 1'b1), 0);

		write_default(32'h0);
		run_random(150, 0);
		write_default(($urandom & 32'hFFFF_FFFE) | 32'h1);
		run_random(150, 0);
		write_default($urandom & 32'hFFFF_FFFE);
		// long random prefixes exhaust the node table
		run_random(40, 1);
		@(posedge clk);
		run_random(90, 0);

		wait_drained();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/ptaf_pkg.sv
rtl/ptaf_ram.sv
rtl/ptaf_cfg.sv
rtl/ptaf_walk.sv
rtl/prefix_trie_access_filter_core.sv
tb/trie_verdict_checker.sv
tb/testbench.sv
